### rtl/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg
// Shared constants, register codes and width helpers of the half-plane clipper.
// ----------------------------------------------------------------------------
package pcl_pkg;

  // Default coordinate width, signed fixed point. The fraction width has no
  // effect on any result because every step of the clip is scale invariant.
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // Depth of the queue between the classifier and the clip engine.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_START_X   = 3'd0,
    REG_LINE_START_Y   = 3'd1,
    REG_LINE_END_X     = 3'd2,
    REG_LINE_END_Y     = 3'd3,
    REG_INSIDE_POINT_X = 3'd4,
    REG_INSIDE_POINT_Y = 3'd5
  } cfg_reg_e;

  // Registers sit at 4-byte steps, or at 8-byte steps once they exceed 32 bits.
  function automatic int unsigned addr_shift(int unsigned cw);
    return (cw > 32) ? 3 : 2;
  endfunction

  function automatic int unsigned paddr_w(int unsigned cw);
    return addr_shift(cw) + CFG_IDX_W;
  endfunction

  function automatic int unsigned pdata_w(int unsigned cw);
    return (cw > 32) ? 64 : 32;
  endfunction

endpackage

### rtl/pcl_vtx_if.sv
// ----------------------------------------------------------------------------
// pcl_vtx_if
// Vertex channel: one polygon vertex per transaction.
// ----------------------------------------------------------------------------
interface pcl_vtx_if #(
  parameter int unsigned COORD_WIDTH = pcl_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          final_vertex;

  modport source (output valid, vertex_x, vertex_y, final_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, final_vertex, output ready);
endinterface

### rtl/pcl_res_if.sv
// ----------------------------------------------------------------------------
// pcl_res_if
// Result channel: one clipped vertex or end marker per transaction.
// ----------------------------------------------------------------------------
interface pcl_res_if #(
  parameter int unsigned COORD_WIDTH = pcl_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic                          end_marker;
  logic                          last_of_run;

  modport source (output valid, out_x, out_y, end_marker, last_of_run, input ready);
  modport sink   (input valid, out_x, out_y, end_marker, last_of_run, output ready);
endinterface

### rtl/pcl_front.sv
// ----------------------------------------------------------------------------
// pcl_front
// Classifier: evaluates side values of the inside point, the vertex, its predecessor
// and the first vertex, keeps the polygon state and pushes one job per vertex.
// ----------------------------------------------------------------------------
module pcl_front #(
  parameter int unsigned COORD_WIDTH = pcl_pkg::COORD_WIDTH_DEF,
  localparam int unsigned D = COORD_WIDTH + 1,
  localparam int unsigned S = 2 * D + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pcl_vtx_if.sink                       vtx_i,
  input  logic signed [COORD_WIDTH-1:0] lsx_i,
  input  logic signed [COORD_WIDTH-1:0] lsy_i,
  input  logic signed [COORD_WIDTH-1:0] lex_i,
  input  logic signed [COORD_WIDTH-1:0] ley_i,
  input  logic signed [COORD_WIDTH-1:0] ipx_i,
  input  logic signed [COORD_WIDTH-1:0] ipy_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic signed [COORD_WIDTH-1:0] cx_o,
  output logic signed [COORD_WIDTH-1:0] cy_o,
  output logic signed [COORD_WIDTH-1:0] px_o,
  output logic signed [COORD_WIDTH-1:0] py_o,
  output logic signed [COORD_WIDTH-1:0] fx_o,
  output logic signed [COORD_WIDTH-1:0] fy_o,
  output logic signed [S-1:0]           sc_o,
  output logic signed [S-1:0]           sp_o,
  output logic signed [S-1:0]           sf_o,
  output logic                          cin_o,
  output logic                          pin_o,
  output logic                          fin_o,
  output logic                          last_o,
  output logic                          hf_o
);
  import pcl_pkg::*;

  typedef enum logic [2:0] {
    FS_IDLE = 3'b001,
    FS_EVAL = 3'b010,
    FS_PUSH = 3'b100
  } fstate_e;

  fstate_e state_q, state_d;
  logic [2:0] k_q;
  logic signed [COORD_WIDTH-1:0] cur_x_q, cur_y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic last_q, first_in_q, prev_in_q, hf_q;
  logic signed [2*D-1:0] pa_q, pb_q;
  logic signed [S-1:0] side_q [4];

  logic signed [COORD_WIDTH-1:0] pt_x, pt_y;
  logic signed [D-1:0] dx, dy, nx, ny;
  logic cneg;
  logic signed [S-1:0] sc, sp, sf;

  // Point evaluated in each step: inside point, vertex, predecessor, first.
  always_comb begin
    case (k_q[1:0])
      2'd0:    begin pt_x = ipx_i;    pt_y = ipy_i;    end
      2'd1:    begin pt_x = cur_x_q;  pt_y = cur_y_q;  end
      2'd2:    begin pt_x = prev_x_q; pt_y = prev_y_q; end
      default: begin
        pt_x = hf_q ? first_x_q : cur_x_q;
        pt_y = hf_q ? first_y_q : cur_y_q;
      end
    endcase
  end

  assign dx = D'(pt_x) - D'(lsx_i);
  assign dy = D'(pt_y) - D'(lsy_i);
  assign nx = D'(lsy_i) - D'(ley_i);
  assign ny = D'(lex_i) - D'(lsx_i);

  // The normal is flipped when the inside point falls behind it.
  assign cneg = side_q[0][S-1];
  assign sc = cneg ? -side_q[1] : side_q[1];
  assign sp = cneg ? -side_q[2] : side_q[2];
  assign sf = cneg ? -side_q[3] : side_q[3];

  assign vtx_i.ready  = (state_q == FS_IDLE);
  assign push_valid_o = (state_q == FS_PUSH);

  assign cx_o   = cur_x_q;
  assign cy_o   = cur_y_q;
  assign px_o   = prev_x_q;
  assign py_o   = prev_y_q;
  assign fx_o   = hf_q ? first_x_q : cur_x_q;
  assign fy_o   = hf_q ? first_y_q : cur_y_q;
  assign sc_o   = sc;
  assign sp_o   = sp;
  assign sf_o   = sf;
  assign cin_o  = ~sc[S-1];
  assign pin_o  = prev_in_q;
  assign fin_o  = hf_q ? first_in_q : ~sc[S-1];
  assign last_o = last_q;
  assign hf_o   = hf_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FS_IDLE: if (vtx_i.valid) state_d = FS_EVAL;
      FS_EVAL: if (k_q == 3'd4) state_d = FS_PUSH;
      FS_PUSH: if (push_ready_i) state_d = FS_IDLE;
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      k_q     <= '0;
      hf_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == FS_IDLE) begin
        k_q <= '0;
      end else if (state_q == FS_EVAL) begin
        k_q <= k_q + 3'd1;
      end
      if (state_q == FS_PUSH && push_ready_i) begin
        hf_q <= ~last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FS_IDLE && vtx_i.valid) begin
      cur_x_q <= vtx_i.vertex_x;
      cur_y_q <= vtx_i.vertex_y;
      last_q  <= vtx_i.final_vertex;
    end
    if (state_q == FS_EVAL) begin
      pa_q <= dx * nx;
      pb_q <= dy * ny;
      if (k_q != 3'd0) begin
        side_q[2'(k_q - 3'd1)] <= S'(pa_q) + S'(pb_q);
      end
    end
    if (state_q == FS_PUSH && push_ready_i) begin
      if (!hf_q) begin
        first_x_q  <= cur_x_q;
        first_y_q  <= cur_y_q;
        first_in_q <= ~sc[S-1];
      end
      prev_x_q  <= cur_x_q;
      prev_y_q  <= cur_y_q;
      prev_in_q <= ~sc[S-1];
    end
  end

endmodule

### rtl/pcl_fifo.sv
// ----------------------------------------------------------------------------
// pcl_fifo
// Small register queue between the classifier and the clip engine.
// ----------------------------------------------------------------------------
module pcl_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = pcl_pkg::QUEUE_DEPTH,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] din_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] dout_o
);
  import pcl_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (AW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= din_i;
    end
  end

endmodule

### rtl/pcl_lerp.sv
// ----------------------------------------------------------------------------
// pcl_lerp
// Intersection coordinate s + (e - s) * ds / den: shift-add multiply, then
// restoring division, one bit per cycle, then add and saturate.
// ----------------------------------------------------------------------------
module pcl_lerp #(
  parameter int unsigned COORD_WIDTH = pcl_pkg::COORD_WIDTH_DEF,
  localparam int unsigned D  = COORD_WIDTH + 1,
  localparam int unsigned S  = 2 * D + 1,
  localparam int unsigned DN = S + 1,
  localparam int unsigned P  = D + S,
  localparam int unsigned CW = $clog2(P + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [COORD_WIDTH-1:0] s_i,
  input  logic signed [COORD_WIDTH-1:0] e_i,
  input  logic signed [S-1:0]           ds_i,
  input  logic signed [DN-1:0]          den_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] res_o
);
  import pcl_pkg::*;

  typedef enum logic [3:0] {
    LS_IDLE = 4'b0001,
    LS_MUL  = 4'b0010,
    LS_DIV  = 4'b0100,
    LS_FIN  = 4'b1000
  } lstate_e;

  localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  lstate_e state_q;
  logic [CW-1:0] cnt_q;
  logic [D-1:0]  a_q;
  logic [S-1:0]  b_q;
  logic [DN-1:0] dm_q, rem_q;
  logic [P-1:0]  acc_q;
  logic          neg_q;
  logic signed [COORD_WIDTH-1:0] s_q;

  logic signed [D-1:0] diff;
  logic [DN:0]   rs;
  logic          qbit;
  logic signed [P+1:0] qv, v;

  assign diff = D'(e_i) - D'(s_i);
  assign rs   = {rem_q, acc_q[P-1]};
  assign qbit = (rs >= {1'b0, dm_q});

  assign qv = neg_q ? -$signed({2'b00, acc_q}) : $signed({2'b00, acc_q});
  assign v  = (P+2)'(s_q) + qv;

  always_comb begin
    if (v > (P+2)'(CMAX)) begin
      res_o = CMAX;
    end else if (v < (P+2)'(CMIN)) begin
      res_o = CMIN;
    end else begin
      res_o = v[COORD_WIDTH-1:0];
    end
  end

  assign done_o = (state_q == LS_FIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LS_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        LS_IDLE: begin
          cnt_q <= '0;
          if (start_i) state_q <= LS_MUL;
        end
        LS_MUL: begin
          if (cnt_q == CW'(D - 1)) begin
            cnt_q   <= '0;
            state_q <= LS_DIV;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        LS_DIV: begin
          if (cnt_q == CW'(P - 1)) begin
            cnt_q   <= '0;
            state_q <= LS_FIN;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        // A new operation may start in the cycle the previous one finishes.
        LS_FIN:  state_q <= start_i ? LS_MUL : LS_IDLE;
        default: state_q <= LS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      LS_IDLE, LS_FIN: begin
        if (start_i) begin
          a_q   <= diff[D-1] ? D'(-diff) : D'(diff);
          b_q   <= ds_i[S-1] ? S'(-ds_i) : S'(ds_i);
          dm_q  <= den_i[DN-1] ? DN'(-den_i) : DN'(den_i);
          neg_q <= diff[D-1] ^ ds_i[S-1] ^ den_i[DN-1];
          s_q   <= s_i;
          acc_q <= '0;
          rem_q <= '0;
        end
      end
      LS_MUL: begin
        acc_q <= {acc_q[P-2:0], 1'b0} + (a_q[D-1] ? P'(b_q) : P'(0));
        a_q   <= {a_q[D-2:0], 1'b0};
      end
      LS_DIV: begin
        rem_q <= qbit ? DN'(rs - {1'b0, dm_q}) : rs[DN-1:0];
        acc_q <= {acc_q[P-2:0], qbit};
      end
      default: ;
    endcase
  end

endmodule

### rtl/pcl_back.sv
// ----------------------------------------------------------------------------
// pcl_back
// Clip engine: turns one job into up to four results, in order.
// ----------------------------------------------------------------------------
module pcl_back #(
  parameter int unsigned COORD_WIDTH = pcl_pkg::COORD_WIDTH_DEF,
  localparam int unsigned D  = COORD_WIDTH + 1,
  localparam int unsigned S  = 2 * D + 1,
  localparam int unsigned DN = S + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  output logic                          job_pop_o,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  input  logic signed [COORD_WIDTH-1:0] fx_i,
  input  logic signed [COORD_WIDTH-1:0] fy_i,
  input  logic signed [S-1:0]           sc_i,
  input  logic signed [S-1:0]           sp_i,
  input  logic signed [S-1:0]           sf_i,
  input  logic                          cin_i,
  input  logic                          pin_i,
  input  logic                          fin_i,
  input  logic                          last_i,
  input  logic                          hf_i,
  pcl_res_if.source                     res_o
);
  import pcl_pkg::*;

  typedef enum logic [4:0] {
    BS_IDLE  = 5'b00001,
    BS_PICK  = 5'b00010,
    BS_LERPX = 5'b00100,
    BS_LERPY = 5'b01000,
    BS_EMIT  = 5'b10000
  } bstate_e;

  bstate_e state_q;
  logic [4:0] mask_q;
  logic signed [COORD_WIDTH-1:0] cx_q, cy_q, px_q, py_q, fx_q, fy_q;
  logic signed [S-1:0] sc_q, sp_q, sf_q;
  logic signed [COORD_WIDTH-1:0] rx_q, ry_q;
  logic rend_q;
  logic out_valid_q, out_end_q, out_last_q;
  logic signed [COORD_WIDTH-1:0] out_x_q, out_y_q;

  logic e2, slot_free, lerp_start, lerp_done;
  logic signed [COORD_WIDTH-1:0] sx, sy, ex, ey, ls, le, lres;
  logic signed [S-1:0] ds, de;
  logic signed [DN-1:0] den;

  // Result order per job: crossing of the incoming edge, the vertex itself,
  // crossing of the closing edge, the first vertex, the end marker.
  // Crossings at bit 0 use the incoming edge, at bit 2 the closing edge.
  assign e2  = ~mask_q[0];
  assign sx  = e2 ? cx_q : px_q;
  assign sy  = e2 ? cy_q : py_q;
  assign ex  = e2 ? fx_q : cx_q;
  assign ey  = e2 ? fy_q : cy_q;
  assign ds  = e2 ? sc_q : sp_q;
  assign de  = e2 ? sf_q : sc_q;
  assign den = DN'(ds) - DN'(de);

  assign slot_free  = ~out_valid_q | res_o.ready;
  assign lerp_start = (state_q == BS_PICK && (mask_q[0] || (!mask_q[1] && mask_q[2]))
                       && den != '0) || (state_q == BS_LERPX && lerp_done);
  assign ls = (state_q == BS_PICK) ? sx : sy;
  assign le = (state_q == BS_PICK) ? ex : ey;

  pcl_lerp #(.COORD_WIDTH(COORD_WIDTH)) u_lerp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lerp_start),
    .s_i     (ls),
    .e_i     (le),
    .ds_i    (ds),
    .den_i   (den),
    .done_o  (lerp_done),
    .res_o   (lres)
  );

  assign job_pop_o = (state_q == BS_IDLE) && job_valid_i;

  assign res_o.valid       = out_valid_q;
  assign res_o.out_x       = out_x_q;
  assign res_o.out_y       = out_y_q;
  assign res_o.end_marker  = out_end_q;
  assign res_o.last_of_run = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == BS_EMIT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        BS_IDLE: begin
          if (job_valid_i) begin
            mask_q  <= {last_i, last_i & fin_i, last_i & (cin_i ^ fin_i),
                        hf_i & cin_i, hf_i & (pin_i ^ cin_i)};
            state_q <= BS_PICK;
          end
        end
        BS_PICK: begin
          if (mask_q == '0) begin
            state_q <= BS_IDLE;
          end else if (lerp_start) begin
            state_q <= BS_LERPX;
          end else begin
            state_q <= BS_EMIT;
          end
        end
        BS_LERPX: if (lerp_done) state_q <= BS_LERPY;
        BS_LERPY: if (lerp_done) state_q <= BS_EMIT;
        BS_EMIT: begin
          if (slot_free) begin
            mask_q  <= mask_q & (mask_q - 5'd1);
            state_q <= BS_PICK;
          end
        end
        default: state_q <= BS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      cx_q <= cx_i;
      cy_q <= cy_i;
      px_q <= px_i;
      py_q <= py_i;
      fx_q <= fx_i;
      fy_q <= fy_i;
      sc_q <= sc_i;
      sp_q <= sp_i;
      sf_q <= sf_i;
    end
    if (state_q == BS_PICK) begin
      if (mask_q[0] || (!mask_q[1] && mask_q[2])) begin
        rx_q   <= sx;
        ry_q   <= sy;
        rend_q <= 1'b0;
      end else if (mask_q[1]) begin
        rx_q   <= cx_q;
        ry_q   <= cy_q;
        rend_q <= 1'b0;
      end else if (mask_q[3]) begin
        rx_q   <= fx_q;
        ry_q   <= fy_q;
        rend_q <= 1'b0;
      end else begin
        rx_q   <= '0;
        ry_q   <= '0;
        rend_q <= 1'b1;
      end
    end
    if (state_q == BS_LERPX && lerp_done) rx_q <= lres;
    if (state_q == BS_LERPY && lerp_done) ry_q <= lres;
    if (state_q == BS_EMIT && slot_free) begin
      out_x_q    <= rx_q;
      out_y_q    <= ry_q;
      out_end_q  <= rend_q;
      out_last_q <= $onehot(mask_q);
    end
  end

  // The end marker always closes the run and carries no coordinates.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_end_q |-> out_last_q)
    else $error("end marker without last_of_run");
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_end_q |-> out_x_q == '0 && out_y_q == '0)
    else $error("end marker with coordinates");
  a_mask_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BS_EMIT && slot_free |=>
      $countones(mask_q) + 1 == $past($countones(mask_q)))
    else $error("pending result lost or repeated");

endmodule

### rtl/polygon_clip_half_plane_core.sv
// ----------------------------------------------------------------------------
// polygon_clip_half_plane_core
// One Sutherland-Hodgman stage: clips a vertex stream against a configured
// half-plane and emits the clipped polygon followed by an end marker.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries per transaction
//  vtx_i     in         vertex_x, vertex_y, final_vertex
//  res_o     out        out_x, out_y, end_marker, last_of_run
//  APB       in/out     writes/reads of the six line and inside-point registers
//
// The classifier computes side values with two 33x33-bit multipliers over
// four points (inside point, vertex, predecessor, first). A plain result is
// emitted by the clip engine without the multiply/divide unit; an
// intersection runs through the bit-serial multiply/divide unit, once for x
// and once for y. A two-entry job queue lets the classifier run ahead while
// the engine or a stalled result output waits. Reset clears all control
// state and the configuration registers; there is no clearing pass. The
// closing edge is processed with the final vertex.
// ----------------------------------------------------------------------------
module polygon_clip_half_plane_core #(
  parameter int unsigned COORD_WIDTH = pcl_pkg::COORD_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  pcl_vtx_if.sink   vtx_i,
  pcl_res_if.source res_o,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [pcl_pkg::paddr_w(COORD_WIDTH)-1:0] paddr,
  input  logic [pcl_pkg::pdata_w(COORD_WIDTH)-1:0] pwdata,
  output logic [pcl_pkg::pdata_w(COORD_WIDTH)-1:0] prdata,
  output logic pready
);
  import pcl_pkg::*;

  localparam int unsigned D    = COORD_WIDTH + 1;
  localparam int unsigned S    = 2 * D + 1;
  localparam int unsigned PAW  = paddr_w(COORD_WIDTH);
  localparam int unsigned PDW  = pdata_w(COORD_WIDTH);
  localparam int unsigned ASH  = addr_shift(COORD_WIDTH);
  localparam int unsigned RECW = 6 * COORD_WIDTH + 3 * S + 5;

  // Configuration registers. The user must see that they are only written while the
  // clipper is idle, so both halves always see one consistent line; the block does not enforce it.
  logic signed [COORD_WIDTH-1:0] lsx_q, lsy_q, lex_q, ley_q, ipx_q, ipy_q;
  logic signed [COORD_WIDTH-1:0] rd_sel;
  cfg_reg_e idx;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign idx    = cfg_reg_e'(paddr[PAW-1:ASH]);
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsx_q <= '0;
      lsy_q <= '0;
      lex_q <= '0;
      ley_q <= '0;
      ipx_q <= '0;
      ipy_q <= '0;
    end else if (cfg_wr) begin
      case (idx)
        REG_LINE_START_X:   lsx_q <= pwdata[COORD_WIDTH-1:0];
        REG_LINE_START_Y:   lsy_q <= pwdata[COORD_WIDTH-1:0];
        REG_LINE_END_X:     lex_q <= pwdata[COORD_WIDTH-1:0];
        REG_LINE_END_Y:     ley_q <= pwdata[COORD_WIDTH-1:0];
        REG_INSIDE_POINT_X: ipx_q <= pwdata[COORD_WIDTH-1:0];
        REG_INSIDE_POINT_Y: ipy_q <= pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the register sign-extended to the bus width.
  always_comb begin
    case (idx)
      REG_LINE_START_X:   rd_sel = lsx_q;
      REG_LINE_START_Y:   rd_sel = lsy_q;
      REG_LINE_END_X:     rd_sel = lex_q;
      REG_LINE_END_Y:     rd_sel = ley_q;
      REG_INSIDE_POINT_X: rd_sel = ipx_q;
      REG_INSIDE_POINT_Y: rd_sel = ipy_q;
      default:            rd_sel = '0;
    endcase
  end
  assign prdata = PDW'(rd_sel);

  // Classifier to queue.
  logic push_valid, q_full, q_empty, pop;
  logic signed [COORD_WIDTH-1:0] f_cx, f_cy, f_px, f_py, f_fx, f_fy;
  logic signed [S-1:0] f_sc, f_sp, f_sf;
  logic f_cin, f_pin, f_fin, f_last, f_hf;
  logic [RECW-1:0] q_din, q_dout;

  pcl_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vtx_i        (vtx_i),
    .lsx_i        (lsx_q),
    .lsy_i        (lsy_q),
    .lex_i        (lex_q),
    .ley_i        (ley_q),
    .ipx_i        (ipx_q),
    .ipy_i        (ipy_q),
    .push_valid_o (push_valid),
    .push_ready_i (~q_full),
    .cx_o         (f_cx),
    .cy_o         (f_cy),
    .px_o         (f_px),
    .py_o         (f_py),
    .fx_o         (f_fx),
    .fy_o         (f_fy),
    .sc_o         (f_sc),
    .sp_o         (f_sp),
    .sf_o         (f_sf),
    .cin_o        (f_cin),
    .pin_o        (f_pin),
    .fin_o        (f_fin),
    .last_o       (f_last),
    .hf_o         (f_hf)
  );

  assign q_din = {f_cx, f_cy, f_px, f_py, f_fx, f_fy, f_sc, f_sp, f_sf,
                  f_cin, f_pin, f_fin, f_last, f_hf};

  pcl_fifo #(.WIDTH(RECW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_valid & ~q_full),
    .full_o  (q_full),
    .din_i   (q_din),
    .pop_i   (pop),
    .empty_o (q_empty),
    .dout_o  (q_dout)
  );

  // Queue to clip engine: unpack the job record.
  logic signed [COORD_WIDTH-1:0] b_cx, b_cy, b_px, b_py, b_fx, b_fy;
  logic signed [S-1:0] b_sc, b_sp, b_sf;
  logic b_cin, b_pin, b_fin, b_last, b_hf;

  assign {b_cx, b_cy, b_px, b_py, b_fx, b_fy, b_sc, b_sp, b_sf,
          b_cin, b_pin, b_fin, b_last, b_hf} = q_dout;

  pcl_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (~q_empty),
    .job_pop_o   (pop),
    .cx_i        (b_cx),
    .cy_i        (b_cy),
    .px_i        (b_px),
    .py_i        (b_py),
    .fx_i        (b_fx),
    .fy_i        (b_fy),
    .sc_i        (b_sc),
    .sp_i        (b_sp),
    .sf_i        (b_sf),
    .cin_i       (b_cin),
    .pin_i       (b_pin),
    .fin_i       (b_fin),
    .last_i      (b_last),
    .hf_i        (b_hf),
    .res_o       (res_o)
  );

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the half-plane polygon clipper. A driver feeds polygon vertices
// from a queue, a monitor checks every clipped vertex and end marker against
// an exact predictor, and the APB port moves the clip line between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pcl_pkg::*;

  localparam int CW = 32;
  localparam int AW = paddr_w(CW);
  localparam int DW = pdata_w(CW);

  typedef logic signed [CW-1:0] coord_t;
  // Side values need room for two products of 33-bit differences.
  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   fin;
  } vertex_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   end_m;
    logic   last;
  } clip_out_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata;
  logic [DW-1:0] prdata;
  logic pready;

  pcl_vtx_if #(.COORD_WIDTH(CW)) vtx_ch ();
  pcl_res_if #(.COORD_WIDTH(CW)) res_ch ();

  polygon_clip_half_plane_core #(.COORD_WIDTH(CW)) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vtx_i   (vtx_ch.sink),
    .res_o   (res_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock with a 10 ns period.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the clip registers and the polygon state of the predictor.
  coord_t  clip_reg [6];
  vertex_t first_vtx, prev_vtx;
  logic    first_in, prev_in, have_first;

  vertex_t   pending_vtx[$];
  clip_out_t clipped_q[$];
  int        error_count = 0;
  int        vtx_sent = 0;
  int        res_seen = 0;
  int        polys_done = 0;
  bit        quiet_phase = 1'b0;

  // Signed side value of a point against the current line; positive or zero
  // means the point lies on the kept side.
  function automatic wide_t side_of(coord_t px, coord_t py);
    wide_t nx, ny, c, v;
    nx = -(wide_t'(clip_reg[REG_LINE_END_Y]) - wide_t'(clip_reg[REG_LINE_START_Y]));
    ny = wide_t'(clip_reg[REG_LINE_END_X]) - wide_t'(clip_reg[REG_LINE_START_X]);
    c = (wide_t'(clip_reg[REG_INSIDE_POINT_X]) - wide_t'(clip_reg[REG_LINE_START_X])) * nx
      + (wide_t'(clip_reg[REG_INSIDE_POINT_Y]) - wide_t'(clip_reg[REG_LINE_START_Y])) * ny;
    v = (wide_t'(px) - wide_t'(clip_reg[REG_LINE_START_X])) * nx
      + (wide_t'(py) - wide_t'(clip_reg[REG_LINE_START_Y])) * ny;
    return (c < 0) ? -v : v;
  endfunction

  // One coordinate of the crossing point, saturated to the coordinate range.
  // SystemVerilog signed division already truncates toward zero.
  function automatic coord_t cross_coord(coord_t s, coord_t e, wide_t ds, wide_t den);
    logic signed [255:0] p, v;
    p = (256'(signed'(wide_t'(e) - wide_t'(s)))) * 256'(signed'(ds));
    v = 256'(signed'(s)) + p / 256'(signed'(den));
    if (v > 256'(signed'(coord_t'({1'b0, {(CW-1){1'b1}}})))) return {1'b0, {(CW-1){1'b1}}};
    if (v < 256'(signed'(coord_t'({1'b1, {(CW-1){1'b0}}})))) return {1'b1, {(CW-1){1'b0}}};
    return v[CW-1:0];
  endfunction

  function automatic clip_out_t make_out(coord_t x, coord_t y, logic end_m);
    clip_out_t o;
    o.x = x; o.y = y; o.end_m = end_m; o.last = 1'b0;
    return o;
  endfunction

  // Results of one edge s->e; a parallel edge yields the start vertex itself.
  task automatic clip_edge(input vertex_t s, input logic s_in, input vertex_t e,
                           input logic e_in, inout clip_out_t outs[$]);
    wide_t ds, den;
    clip_out_t xo;
    if (s_in != e_in) begin
      ds  = side_of(s.x, s.y);
      den = ds - side_of(e.x, e.y);
      if (den == 0) xo = make_out(s.x, s.y, 1'b0);
      else xo = make_out(cross_coord(s.x, e.x, ds, den), cross_coord(s.y, e.y, ds, den), 1'b0);
      outs.insert(outs.size(), xo);
    end
    if (e_in) outs.insert(outs.size(), make_out(e.x, e.y, 1'b0));
  endtask

  // Expected results of one accepted vertex, appended to the result store.
  task automatic predict_clip(input vertex_t v);
    clip_out_t outs[$];
    logic v_in;
    v_in = (side_of(v.x, v.y) >= 0);
    if (!have_first) begin
      first_vtx = v; first_in = v_in; have_first = 1'b1;
    end else begin
      clip_edge(prev_vtx, prev_in, v, v_in, outs);
    end
    prev_vtx = v;
    prev_in  = v_in;
    if (v.fin) begin
      clip_edge(v, v_in, first_vtx, first_in, outs);
      outs.insert(outs.size(), make_out('0, '0, 1'b1));
      have_first = 1'b0;
    end
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) clipped_q.insert(clipped_q.size(), outs[i]);
  endtask

  // Driver: presents queued vertices with random gaps, except in quiet phases.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_ch.valid        <= 1'b0;
      vtx_ch.vertex_x     <= '0;
      vtx_ch.vertex_y     <= '0;
      vtx_ch.final_vertex <= 1'b0;
    end else begin
      if (vtx_ch.valid && vtx_ch.ready) begin
        predict_clip({vtx_ch.vertex_x, vtx_ch.vertex_y, vtx_ch.final_vertex});
        vtx_sent++;
      end
      if (!vtx_ch.valid || vtx_ch.ready) begin
        if (pending_vtx.size() > 0 && (quiet_phase || $urandom_range(99) >= 32)) begin
          vtx_ch.valid        <= 1'b1;
          vtx_ch.vertex_x     <= pending_vtx[0].x;
          vtx_ch.vertex_y     <= pending_vtx[0].y;
          vtx_ch.final_vertex <= pending_vtx[0].fin;
          void'(pending_vtx.pop_front());
        end else begin
          vtx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and a field-by-field check of each result.
  always @(posedge clk_i or negedge rst_ni) begin
    clip_out_t want;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        res_seen++;
        if (res_ch.end_marker) polys_done++;
        if (clipped_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d end=%b last=%b", $time,
                   res_ch.out_x, res_ch.out_y, res_ch.end_marker, res_ch.last_of_run);
          error_count++;
        end else begin
          want = clipped_q.pop_front();
          if (res_ch.out_x !== want.x || res_ch.out_y !== want.y ||
              res_ch.end_marker !== want.end_m || res_ch.last_of_run !== want.last) begin
            $display("%0t: mismatch expected x=%0d y=%0d end=%b last=%b", $time,
                     want.x, want.y, want.end_m, want.last);
            $display("%0t:          actual   x=%0d y=%0d end=%b last=%b", $time,
                     res_ch.out_x, res_ch.out_y, res_ch.end_marker, res_ch.last_of_run);
            error_count++;
          end
        end
      end
      res_ch.ready <= quiet_phase || ($urandom_range(99) >= 32);
    end
  end

  task automatic apb_write(input cfg_reg_e idx, input coord_t val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'(idx) << addr_shift(CW);
    pwdata  <= DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    clip_reg[idx] = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_line(input coord_t sx, input coord_t sy, input coord_t ex,
                          input coord_t ey, input coord_t ix, input coord_t iy);
    apb_write(REG_LINE_START_X, sx);
    apb_write(REG_LINE_START_Y, sy);
    apb_write(REG_LINE_END_X, ex);
    apb_write(REG_LINE_END_Y, ey);
    apb_write(REG_INSIDE_POINT_X, ix);
    apb_write(REG_INSIDE_POINT_Y, iy);
  endtask

  // Waits until every queued vertex went in and every expected result came
  // out, then lets the engine settle: a vertex with no result may still be
  // in flight, and an intersection is computed bit-serially.
  task automatic drain_block();
    while (pending_vtx.size() > 0 || vtx_ch.valid || clipped_q.size() > 0)
      @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  function automatic coord_t rand_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(200)) - 100;
      default: return coord_t'(($urandom_range(2000) - 1000) <<< 16);
    endcase
  endfunction

  // A polygon of n vertices with random content; the last one is final.
  task automatic queue_polygon(input int n, input int mode);
    vertex_t v;
    for (int i = 0; i < n; i++) begin
      v.x = rand_coord(mode);
      v.y = rand_coord(mode);
      v.fin = (i == n - 1);
      pending_vtx.insert(pending_vtx.size(), v);
    end
  endtask

  task automatic queue_vtx(input coord_t x, input coord_t y, input logic fin);
    vertex_t v;
    v.x = x; v.y = y; v.fin = fin;
    pending_vtx.insert(pending_vtx.size(), v);
  endtask

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  initial begin
    int n_rand;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    foreach (clip_reg[i]) clip_reg[i] = '0;
    have_first = 1'b0; first_in = 1'b0; prev_in = 1'b0;
    first_vtx = '0; prev_vtx = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset line is degenerate, so a quadrilateral passes unchanged; then a
    // single-vertex polygon at the coordinate extremes.
    queue_vtx(0, 0, 1'b0); queue_vtx(CMAX, 0, 1'b0); queue_vtx(CMAX, CMAX, 1'b0);
    queue_vtx(CMIN, CMAX, 1'b1);
    queue_vtx(CMIN, CMIN, 1'b1);
    drain_block();

    // Vertical line x = 0, kept side x >= 0: crossings in both directions,
    // a vertex on the line, and a one-vertex polygon outside. Both sides run
    // without gaps here.
    quiet_phase = 1'b1;
    set_line(0, CMIN, 0, CMAX, 32'sh0001_0000, 0);
    queue_vtx(-32'sh0002_0000, -32'sh0002_0000, 1'b0);
    queue_vtx(32'sh0002_0000, -32'sh0001_0000, 1'b0);
    queue_vtx(32'sh0003_0000, 32'sh0002_0000, 1'b0);
    queue_vtx(0, 32'sh0001_0000, 1'b0);
    queue_vtx(-32'sh0001_0001, 32'sh0003_0000, 1'b1);
    queue_vtx(-5, 7, 1'b1);
    // Extreme coordinates crossing the line: the quotient runs wide.
    queue_vtx(CMIN, CMIN, 1'b0); queue_vtx(CMAX, CMAX, 1'b0); queue_vtx(CMAX, CMIN, 1'b1);
    drain_block();
    quiet_phase = 1'b0;

    // Extreme line: inside point in front of the normal, so it does not flip.
    set_line(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN);
    queue_vtx(CMAX, CMAX, 1'b0); queue_vtx(CMIN, CMIN, 1'b0);
    queue_vtx(0, 0, 1'b0); queue_vtx(CMAX, CMIN, 1'b1);
    drain_block();

    // Random part: polygons mostly of small integer or Q16.16 values so both
    // sides are hit, with some full-range noise and changing lines.
    n_rand = 0;
    while (n_rand < 220) begin
      int mode, nv;
      mode = ($urandom_range(9) < 2) ? 0 : ($urandom_range(1) ? 1 : 2);
      if ($urandom_range(3) == 0) begin
        drain_block();
        if ($urandom_range(4) == 0)
          set_line(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                   coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        else
          set_line(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                   rand_coord(mode), rand_coord(mode), rand_coord(mode));
        quiet_phase = ($urandom_range(5) == 0);
      end
      nv = ($urandom_range(7) == 0) ? 1 : $urandom_range(8, 2);
      queue_polygon(nv, mode);
      n_rand += nv;
    end
    quiet_phase = 1'b0;
    drain_block();

    $display("Covered %0d vertices and %0d results over %0d finished polygons.",
             vtx_sent, res_seen, polys_done);
    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
rtl/pcl_pkg.sv
rtl/pcl_vtx_if.sv
rtl/pcl_res_if.sv
rtl/pcl_front.sv
rtl/pcl_fifo.sv
rtl/pcl_lerp.sv
rtl/pcl_back.sv
rtl/polygon_clip_half_plane_core.sv
test/tb_top.sv
